// ===== rtl/jrms_pkg.sv =====
// Shared types and constants for the JPEG restart marker sync unit.
// Used by every module in rtl/; has no dependencies of its own.
package jrms_pkg;

   // Search sequencer phases
   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_SEEK  = 4'd1,
      PH_GOTFF = 4'd2,
      PH_RSYNC = 4'd3,
      PH_RSFF  = 4'd4,
      PH_LEN1  = 4'd5,
      PH_LEN2  = 4'd6,
      PH_HGT1  = 4'd7,
      PH_HGT2  = 4'd8
   } phase_type;

   // Result event codes
   typedef enum logic [2:0] {
      EV_CONSUMED = 3'd0,
      EV_RESTART  = 3'd1,
      EV_SKIPPED  = 3'd2,
      EV_DNL      = 3'd3,
      EV_LEFT     = 3'd4,
      EV_EOF      = 3'd5,
      EV_BADSIZE  = 3'd6,
      EV_ZEROH    = 3'd7
   } event_type;

   // Item kinds
   localparam logic KIND_ARM  = 1'b0;
   localparam logic KIND_BYTE = 1'b1;

   // Marker byte codes
   localparam logic [7:0]  FILL_BYTE    = 8'hFF;
   localparam logic [7:0]  DNL_CODE     = 8'hDC;
   localparam logic [4:0]  RST_PREFIX   = 5'b11010;  // D0..D7
   localparam logic [1:0]  MRK_PREFIX   = 2'b11;     // C0..FF
   localparam logic [1:0]  MRK_EXCL_NIB = 2'b11;     // excludes F0..FF
   localparam logic [15:0] DNL_LENGTH   = 16'h0004;
   localparam logic [1:0]  PUSHBACK_TWO = 2'd2;

   typedef struct packed {
      phase_type   phase;
      logic [2:0]  index;
      logic        seg_ok;
      logic        height_seen;
      logic [7:0]  held;
   } state_type;

   typedef struct packed {
      event_type   event_res;
      logic        out_of_sync;
      logic [1:0]  pushback;
      logic [15:0] image_height;
      logic [2:0]  expected_index;
      logic        segment_valid;
      logic        search_done;
   } result_type;

endpackage

// ===== rtl/jpeg_restart_marker_sync_unit.sv =====
// Results: each result is registered in the output buffer, or in its skid entry while rsp_ is stalled.
// Throughput: one item per cycle; req_stall rises only while the skid entry
//   holds a result, which happens after rsp_stall blocks a pending result.
// Reset (synchronous, active high): search idle, expected index 0, segment
//   valid, no DNL seen, DNL scanning off, result and skid entries empty.
// Depends on jrms_pkg, jrms_step and jrms_out_buf.
module jpeg_restart_marker_sync_unit (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   // item input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_stream_byte,
   input  logic        req_at_end,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_event_res,
   output logic        rsp_out_of_sync,
   output logic [1:0]  rsp_pushback,
   output logic [15:0] rsp_image_height,
   output logic [2:0]  rsp_expected_index,
   output logic        rsp_segment_valid,
   output logic        rsp_search_done
);

   // Search state is updated at the transfer itself, so the next byte sees it
   // in the very next cycle; the result goes to the output buffer.
   jrms_pkg::state_type  state_ff, state_in;
   jrms_pkg::result_type step_res, rsp_res;
   logic                 scan_dnl_ff;
   logic                 req_xfer;

   assign req_xfer = req_valid && !req_stall;

   jrms_step u_step (
      .kind         (req_kind),
      .stream_byte  (req_stream_byte),
      .at_end       (req_at_end),
      .scan_for_dnl (scan_dnl_ff),
      .cur          (state_ff),
      .nxt          (state_in),
      .res          (step_res)
   );

   jrms_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_vld    (req_xfer),
      .in_res    (step_res),
      .in_stall  (req_stall),
      .out_vld   (rsp_valid),
      .out_stall (rsp_stall),
      .out_res   (rsp_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase       <= jrms_pkg::PH_IDLE;
         state_ff.index       <= 3'd0;
         state_ff.seg_ok      <= 1'b1;
         state_ff.height_seen <= 1'b0;
         state_ff.held        <= 8'd0;
         scan_dnl_ff          <= 1'b0;
      end else begin
         if (req_xfer) begin
            state_ff <= state_in;
         end
         if (csr_wr_en) begin
            scan_dnl_ff <= csr_wr_data;
         end
      end
   end

   assign rsp_event_res      = rsp_res.event_res;
   assign rsp_out_of_sync    = rsp_res.out_of_sync;
   assign rsp_pushback       = rsp_res.pushback;
   assign rsp_image_height   = rsp_res.image_height;
   assign rsp_expected_index = rsp_res.expected_index;
   assign rsp_segment_valid  = rsp_res.segment_valid;
   assign rsp_search_done    = rsp_res.search_done;

`ifndef SYNTH
   // arm item always restarts the search
   a_arm_seek: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_kind == jrms_pkg::KIND_ARM) |=> state_ff.phase == jrms_pkg::PH_SEEK)
      else $error("arm transfer did not start the marker search");

   // restart or skip advances the expected index by one
   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (step_res.event_res == jrms_pkg::EV_RESTART ||
                   step_res.event_res == jrms_pkg::EV_SKIPPED)
      |=> state_ff.index == 3'($past(state_ff.index) + 3'd1))
      else $error("expected index did not advance on restart or skip");

   // bytes while idle leave the state alone
   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_kind == jrms_pkg::KIND_BYTE) &&
      (state_ff.phase == jrms_pkg::PH_IDLE)
      |=> $stable(state_ff))
      else $error("idle byte changed the search state");

   // result reports the post-step index and segment flag
   a_res_state: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff.index == $past(step_res.expected_index) &&
                   state_ff.seg_ok == $past(step_res.segment_valid))
      else $error("result index disagrees with stored index");
`endif

endmodule

// ===== rtl/jrms_step.sv =====
// Per-item combinational step: next search state and result for one item.
// Depends on jrms_pkg.
module jrms_step (
   input  logic               kind,
   input  logic [7:0]         stream_byte,
   input  logic               at_end,
   input  logic               scan_for_dnl,
   input  jrms_pkg::state_type cur,
   output jrms_pkg::state_type nxt,
   output jrms_pkg::result_type res
);

   logic       is_ff;
   logic       is_rst;
   logic       is_mrk;
   logic       is_dnl;
   logic [2:0] rst_dist;
   logic       rst_match;
   logic       rst_stale;
   logic       rs_restart;   // resync word takes the restart
   logic       rs_skip;      // resync word skips the segment
   logic [15:0] word16;
   jrms_pkg::phase_type nxt_phase;

   assign is_ff     = (stream_byte == jrms_pkg::FILL_BYTE);
   assign is_rst    = (stream_byte[7:3] == jrms_pkg::RST_PREFIX);
   assign is_mrk    = (stream_byte[7:6] == jrms_pkg::MRK_PREFIX) &&
                      (stream_byte[5:4] != jrms_pkg::MRK_EXCL_NIB);
   assign is_dnl    = (stream_byte == jrms_pkg::DNL_CODE) && scan_for_dnl;
   assign rst_dist  = stream_byte[2:0] - cur.index;
   assign rst_match = is_rst && (rst_dist == 3'd0);
   assign rst_stale = is_rst && rst_dist[2];
   assign rs_restart = rst_match;
   assign rs_skip    = (is_rst && !rst_match && !rst_stale) || (!is_rst && is_mrk);
   assign word16     = {cur.held, stream_byte};

   // Next phase
   always_comb begin
      nxt_phase = cur.phase;
      if (kind == jrms_pkg::KIND_ARM) begin
         nxt_phase = jrms_pkg::PH_SEEK;
      end else if (cur.phase == jrms_pkg::PH_IDLE) begin
         nxt_phase = jrms_pkg::PH_IDLE;
      end else if (at_end) begin
         nxt_phase = jrms_pkg::PH_IDLE;
      end else begin
         case (cur.phase)
            jrms_pkg::PH_SEEK: begin
               nxt_phase = is_ff ? jrms_pkg::PH_GOTFF : jrms_pkg::PH_RSYNC;
            end
            jrms_pkg::PH_GOTFF: begin
               if (is_ff) begin
                  nxt_phase = jrms_pkg::PH_GOTFF;
               end else if (is_dnl) begin
                  nxt_phase = cur.height_seen ? jrms_pkg::PH_IDLE : jrms_pkg::PH_LEN1;
               end else if (rs_restart || rs_skip) begin
                  nxt_phase = jrms_pkg::PH_IDLE;
               end else if (is_ff) begin
                  nxt_phase = jrms_pkg::PH_RSFF;
               end else begin
                  nxt_phase = jrms_pkg::PH_RSYNC;
               end
            end
            jrms_pkg::PH_RSYNC: begin
               nxt_phase = is_ff ? jrms_pkg::PH_RSFF : jrms_pkg::PH_RSYNC;
            end
            jrms_pkg::PH_RSFF: begin
               if (rs_restart || rs_skip) begin
                  nxt_phase = jrms_pkg::PH_IDLE;
               end else if (is_ff) begin
                  nxt_phase = jrms_pkg::PH_RSFF;
               end else begin
                  nxt_phase = jrms_pkg::PH_RSYNC;
               end
            end
            jrms_pkg::PH_LEN1: begin
               nxt_phase = jrms_pkg::PH_LEN2;
            end
            jrms_pkg::PH_LEN2: begin
               nxt_phase = (word16 == jrms_pkg::DNL_LENGTH) ? jrms_pkg::PH_HGT1
                                                           : jrms_pkg::PH_IDLE;
            end
            jrms_pkg::PH_HGT1: begin
               nxt_phase = jrms_pkg::PH_HGT2;
            end
            default: begin
               nxt_phase = jrms_pkg::PH_IDLE;
            end
         endcase
      end
   end

   // Result fields and the rest of the state
   always_comb begin
      nxt.phase       = nxt_phase;
      nxt.index       = cur.index;
      nxt.seg_ok      = cur.seg_ok;
      nxt.height_seen = cur.height_seen;
      nxt.held        = cur.held;
      res.event_res    = jrms_pkg::EV_CONSUMED;
      res.out_of_sync  = 1'b0;
      res.pushback     = 2'd0;
      res.image_height = 16'd0;
      res.search_done  = 1'b0;
      if (kind == jrms_pkg::KIND_ARM || cur.phase == jrms_pkg::PH_IDLE) begin
         // nothing changes
      end else if (at_end) begin
         res.event_res = (cur.phase == jrms_pkg::PH_LEN1 || cur.phase == jrms_pkg::PH_LEN2)
                         ? jrms_pkg::EV_BADSIZE : jrms_pkg::EV_EOF;
         res.out_of_sync = (cur.phase == jrms_pkg::PH_SEEK) ||
                           (cur.phase == jrms_pkg::PH_GOTFF);
         res.search_done = 1'b1;
      end else begin
         case (cur.phase)
            jrms_pkg::PH_SEEK: begin
               res.out_of_sync = !is_ff;
            end
            jrms_pkg::PH_GOTFF, jrms_pkg::PH_RSFF: begin
               if (cur.phase == jrms_pkg::PH_GOTFF && is_ff) begin
                  // more fill
               end else if (cur.phase == jrms_pkg::PH_GOTFF && is_dnl) begin
                  if (cur.height_seen) begin
                     res.event_res   = jrms_pkg::EV_LEFT;
                     res.pushback    = jrms_pkg::PUSHBACK_TWO;
                     res.search_done = 1'b1;
                  end
               end else begin
                  // unexpected word in the marker search raises the warning
                  res.out_of_sync = (cur.phase == jrms_pkg::PH_GOTFF) && !rst_match;
                  if (rs_restart) begin
                     res.event_res   = jrms_pkg::EV_RESTART;
                     nxt.index       = cur.index + 3'd1;
                     nxt.seg_ok      = 1'b1;
                     res.search_done = 1'b1;
                  end else if (rs_skip) begin
                     res.event_res   = jrms_pkg::EV_SKIPPED;
                     nxt.index       = cur.index + 3'd1;
                     nxt.seg_ok      = 1'b0;
                     res.pushback    = jrms_pkg::PUSHBACK_TWO;
                     res.search_done = 1'b1;
                  end
               end
            end
            jrms_pkg::PH_LEN1, jrms_pkg::PH_HGT1: begin
               nxt.held = stream_byte;
            end
            jrms_pkg::PH_LEN2: begin
               if (word16 != jrms_pkg::DNL_LENGTH) begin
                  res.event_res   = jrms_pkg::EV_BADSIZE;
                  res.search_done = 1'b1;
               end
            end
            jrms_pkg::PH_HGT2: begin
               if (word16 == 16'd0) begin
                  res.event_res = jrms_pkg::EV_ZEROH;
               end else begin
                  res.event_res    = jrms_pkg::EV_DNL;
                  res.image_height = word16;
                  nxt.height_seen  = 1'b1;
               end
               res.search_done = 1'b1;
            end
            default: begin
               // resync scan consumes bytes with a plain consumed result
            end
         endcase
      end
      res.expected_index = nxt.index;
      res.segment_valid  = nxt.seg_ok;
   end

endmodule

// ===== rtl/jrms_out_buf.sv =====
// Result register with one skid entry between the step logic and rsp_ channel.
// Depends on jrms_pkg.
module jrms_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_vld,
   input  jrms_pkg::result_type in_res,
   output logic                 in_stall,
   output logic                 out_vld,
   input  logic                 out_stall,
   output jrms_pkg::result_type out_res
);

   logic                 out_vld_ff, out_vld_in;
   logic                 skid_vld_ff, skid_vld_in;
   jrms_pkg::result_type out_res_ff, out_res_in;
   jrms_pkg::result_type skid_res_ff, skid_res_in;

   assign in_stall = skid_vld_ff;
   assign out_vld  = out_vld_ff;
   assign out_res  = out_res_ff;

   always_comb begin
      out_vld_in  = out_vld_ff;
      out_res_in  = out_res_ff;
      skid_vld_in = skid_vld_ff;
      skid_res_in = skid_res_ff;
      if (!out_vld_ff || !out_stall) begin
         // output slot frees: skid entry is older, so it goes first
         out_vld_in  = skid_vld_ff || in_vld;
         out_res_in  = skid_vld_ff ? skid_res_ff : in_res;
         skid_vld_in = 1'b0;
      end else if (in_vld) begin
         skid_vld_in = 1'b1;
         skid_res_in = in_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      out_res_ff  <= out_res_in;
      skid_res_ff <= skid_res_in;
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for jpeg_restart_marker_sync_unit: marker search,
// resync, DNL parsing and end-of-stream handling, checked against a tracker.
// Depends on rtl/jrms_pkg.sv and the unit's RTL; needs no files at run time.
module tb_top;

   localparam int CYCLE_LIMIT   = 200000;  // many times the slowest legal run
   localparam int SETTLE_CYCLES = 4;       // idle wait after the result queue drains
   localparam int HOLD_CYCLES   = 150;     // long receiver hold-off
   localparam int REPORT_MAX    = 10;

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = jrms_pkg::KIND_ARM;
   logic [7:0]  req_stream_byte = 8'h00;
   logic        req_at_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_event_res;
   logic        rsp_out_of_sync;
   logic [1:0]  rsp_pushback;
   logic [15:0] rsp_image_height;
   logic [2:0]  rsp_expected_index;
   logic        rsp_segment_valid;
   logic        rsp_search_done;

   jpeg_restart_marker_sync_unit dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_stream_byte    (req_stream_byte),
      .req_at_end         (req_at_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_res      (rsp_event_res),
      .rsp_out_of_sync    (rsp_out_of_sync),
      .rsp_pushback       (rsp_pushback),
      .rsp_image_height   (rsp_image_height),
      .rsp_expected_index (rsp_expected_index),
      .rsp_segment_valid  (rsp_segment_valid),
      .rsp_search_done    (rsp_search_done)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // ------------------------------------------------------------------
   // Tracker: our own copy of the sync state, advanced once per transfer
   // ------------------------------------------------------------------
   jrms_pkg::phase_type trk_phase       = jrms_pkg::PH_IDLE;
   logic [2:0]          trk_index       = 3'd0;
   logic                trk_seg_ok      = 1'b1;
   logic                trk_height_seen = 1'b0;
   logic [7:0]          trk_held        = 8'h00;
   logic                trk_dnl_scan    = 1'b0;

   jrms_pkg::result_type sync_results_due[$];   // expected results, oldest first
   int unsigned search_items = 0;      // transfers the unit did not just ignore
   int unsigned bad_results  = 0;
   int unsigned snd_idle_pct = 0;
   int unsigned rcv_idle_pct = 0;
   int unsigned cycle_cnt    = 0;
   int unsigned hold_cnt     = 0;
   logic        hold_go      = 1'b0;

   // Expected restart taken: index moves on, segment trusted again.
   function automatic void take_restart(inout jrms_pkg::result_type r);
      r.event_res   = jrms_pkg::EV_RESTART;
      r.search_done = 1'b1;
      trk_index     = trk_index + 3'd1;
      trk_seg_ok    = 1'b1;
      trk_phase     = jrms_pkg::PH_IDLE;
   endfunction

   // Newer RST or other marker: give up on this segment, hand back FF xx.
   function automatic void skip_segment(inout jrms_pkg::result_type r);
      r.event_res   = jrms_pkg::EV_SKIPPED;
      r.pushback    = jrms_pkg::PUSHBACK_TWO;
      r.search_done = 1'b1;
      trk_index     = trk_index + 3'd1;
      trk_seg_ok    = 1'b0;
      trk_phase     = jrms_pkg::PH_IDLE;
   endfunction

   // Second byte of an FF xx word seen while out of sync.
   function automatic void resync_on_word(input logic [7:0] b,
                                          inout jrms_pkg::result_type r);
      logic [2:0] ahead;
      ahead = b[2:0] - trk_index;
      if (b[7:3] == jrms_pkg::RST_PREFIX) begin
         if (ahead == 3'd0)
            take_restart(r);
         else if (ahead >= 3'd4)
            trk_phase = jrms_pkg::PH_RSYNC;   // stale RST, eat it
         else
            skip_segment(r);
      end else if (b[7:6] == jrms_pkg::MRK_PREFIX && b[5:4] != jrms_pkg::MRK_EXCL_NIB) begin
         skip_segment(r);
      end else if (b == jrms_pkg::FILL_BYTE) begin
         trk_phase = jrms_pkg::PH_RSFF;
      end else begin
         trk_phase = jrms_pkg::PH_RSYNC;
      end
   endfunction

   function automatic jrms_pkg::result_type predict_sync_step(input logic kind,
                                                              input logic [7:0] b,
                                                              input logic at_end);
      jrms_pkg::result_type r;
      jrms_pkg::phase_type  ph;
      r  = '0;
      ph = trk_phase;
      if (kind == jrms_pkg::KIND_ARM) begin
         trk_phase = jrms_pkg::PH_SEEK;
      end else if (ph == jrms_pkg::PH_IDLE) begin
         trk_phase = jrms_pkg::PH_IDLE;
      end else if (at_end) begin
         if (ph == jrms_pkg::PH_LEN1 || ph == jrms_pkg::PH_LEN2)
            r.event_res = jrms_pkg::EV_BADSIZE;
         else
            r.event_res = jrms_pkg::EV_EOF;
         r.out_of_sync = (ph == jrms_pkg::PH_SEEK || ph == jrms_pkg::PH_GOTFF);
         r.search_done = 1'b1;
         trk_phase     = jrms_pkg::PH_IDLE;
      end else begin
         case (ph)
            jrms_pkg::PH_SEEK: begin
               if (b == jrms_pkg::FILL_BYTE) begin
                  trk_phase = jrms_pkg::PH_GOTFF;
               end else begin
                  r.out_of_sync = 1'b1;
                  trk_phase     = jrms_pkg::PH_RSYNC;
               end
            end
            jrms_pkg::PH_GOTFF: begin
               if (b == jrms_pkg::FILL_BYTE) begin
                  trk_phase = jrms_pkg::PH_GOTFF;
               end else if (b == jrms_pkg::DNL_CODE && trk_dnl_scan) begin
                  if (trk_height_seen) begin
                     r.event_res   = jrms_pkg::EV_LEFT;
                     r.pushback    = jrms_pkg::PUSHBACK_TWO;
                     r.search_done = 1'b1;
                     trk_phase     = jrms_pkg::PH_IDLE;
                  end else begin
                     trk_phase = jrms_pkg::PH_LEN1;
                  end
               end else if (b == {jrms_pkg::RST_PREFIX, trk_index}) begin
                  take_restart(r);
               end else begin
                  r.out_of_sync = 1'b1;
                  resync_on_word(b, r);
               end
            end
            jrms_pkg::PH_RSYNC:
               trk_phase = (b == jrms_pkg::FILL_BYTE) ? jrms_pkg::PH_RSFF : jrms_pkg::PH_RSYNC;
            jrms_pkg::PH_RSFF:  resync_on_word(b, r);
            jrms_pkg::PH_LEN1: begin
               trk_held  = b;
               trk_phase = jrms_pkg::PH_LEN2;
            end
            jrms_pkg::PH_LEN2: begin
               if ({trk_held, b} != jrms_pkg::DNL_LENGTH) begin
                  r.event_res   = jrms_pkg::EV_BADSIZE;
                  r.search_done = 1'b1;
                  trk_phase     = jrms_pkg::PH_IDLE;
               end else begin
                  trk_phase = jrms_pkg::PH_HGT1;
               end
            end
            jrms_pkg::PH_HGT1: begin
               trk_held  = b;
               trk_phase = jrms_pkg::PH_HGT2;
            end
            default: begin
               if ({trk_held, b} == 16'h0000) begin
                  r.event_res = jrms_pkg::EV_ZEROH;
               end else begin
                  r.event_res     = jrms_pkg::EV_DNL;
                  r.image_height  = {trk_held, b};
                  trk_height_seen = 1'b1;
               end
               r.search_done = 1'b1;
               trk_phase     = jrms_pkg::PH_IDLE;
            end
         endcase
      end
      r.expected_index = trk_index;
      r.segment_valid  = trk_seg_ok;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------
   // Valid stays high between back-to-back items; it is only lowered for a gap.
   task automatic send_item(input logic kind, input logic [7:0] b, input logic at_end);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_stream_byte <= b;
      req_at_end      <= at_end;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      // transfer taken at this edge
      if (kind == jrms_pkg::KIND_ARM || trk_phase != jrms_pkg::PH_IDLE)
         search_items++;
      sync_results_due.push_back(predict_sync_step(kind, b, at_end));
   endtask

   task automatic arm_search();
      send_item(jrms_pkg::KIND_ARM, 8'($urandom_range(255)), 1'b0);
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(jrms_pkg::KIND_BYTE, b, 1'b0);
   endtask

   task automatic send_end();
      send_item(jrms_pkg::KIND_BYTE, 8'($urandom_range(255)), 1'b1);
   endtask

   // Stream byte that now and then turns into an end of stream.
   task automatic send_stream_byte(input logic [7:0] b);
      if ($urandom_range(99) < 3)
         send_end();
      else
         send_byte(b);
   endtask

   // Second byte of a marker word, spread over every interesting class.
   function automatic logic [7:0] pick_marker();
      case ($urandom_range(6))
         0:       return {jrms_pkg::RST_PREFIX, trk_index};          // the one we want
         1:       return {jrms_pkg::RST_PREFIX, 3'($urandom_range(7))};
         2:       return 8'($urandom_range(8'hC0, 8'hEF));
         3:       return 8'($urandom_range(8'hF0, 8'hFE));
         4:       return jrms_pkg::FILL_BYTE;
         5:       return jrms_pkg::DNL_CODE;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Mostly one arm followed by a mostly well-formed byte sequence; now and then a short burst of noise.
   task automatic run_random_search();
      int unsigned pick;
      logic [15:0] word;
      pick = $urandom_range(99);
      if (pick < 10) begin
         // noise: anything, including bytes while idle and stray arms
         repeat ($urandom_range(1, 4))
            send_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                      $urandom_range(99) < 5);
         return;
      end
      arm_search();
      if (pick < 45) begin
         // clean restart, with fill bytes in front
         repeat ($urandom_range(1, 3))
            send_stream_byte(jrms_pkg::FILL_BYTE);
         send_stream_byte({jrms_pkg::RST_PREFIX, trk_index});
      end else if (pick < 70) begin
         // lost sync: garbage, then one or more marker words
         repeat ($urandom_range(1, 5))
            send_stream_byte(8'($urandom_range(255)));
         repeat ($urandom_range(1, 3)) begin
            send_stream_byte(jrms_pkg::FILL_BYTE);
            send_stream_byte(pick_marker());
         end
      end else if (pick < 80) begin
         repeat ($urandom_range(1, 2)) begin
            send_stream_byte(jrms_pkg::FILL_BYTE);
            send_stream_byte(pick_marker());
         end
      end else begin
         // DNL segment, mostly with the right length
         send_stream_byte(jrms_pkg::FILL_BYTE);
         send_stream_byte(jrms_pkg::DNL_CODE);
         word = ($urandom_range(99) < 80) ? jrms_pkg::DNL_LENGTH : 16'($urandom);
         send_stream_byte(word[15:8]);
         send_stream_byte(word[7:0]);
         word = ($urandom_range(99) < 10) ? 16'h0000 : 16'($urandom);
         send_stream_byte(word[15:8]);
         send_stream_byte(word[7:0]);
      end
   endtask

   // Register write, only once the unit has drained.
   task automatic write_dnl_scan(input logic value);
      req_valid <= 1'b0;
      while (sync_results_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      trk_dnl_scan = value;
      csr_wr_en   <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Receiver side: check every transfer, then pick next cycle's stall
   // ------------------------------------------------------------------
   always @(posedge clock) begin : rsp_side
      jrms_pkg::result_type got;
      jrms_pkg::result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.event_res      = jrms_pkg::event_type'(rsp_event_res);
         got.out_of_sync    = rsp_out_of_sync;
         got.pushback       = rsp_pushback;
         got.image_height   = rsp_image_height;
         got.expected_index = rsp_expected_index;
         got.segment_valid  = rsp_segment_valid;
         got.search_done    = rsp_search_done;
         if (sync_results_due.size() == 0) begin
            bad_results++;
            if (bad_results <= REPORT_MAX)
               $display("%0t: result with nothing pending, event %0d", $realtime,
                        rsp_event_res);
         end else begin
            want = sync_results_due.pop_front();
            if (got !== want) begin
               bad_results++;
               if (bad_results <= REPORT_MAX)
                  $display({"%0t: mismatch (exp/got) ev %0d/%0d oos %b/%b pb %0d/%0d ",
                            "h %h/%h idx %0d/%0d seg %b/%b done %b/%b"}, $realtime,
                           want.event_res, got.event_res, want.out_of_sync,
                           got.out_of_sync, want.pushback, got.pushback,
                           want.image_height, got.image_height, want.expected_index,
                           got.expected_index, want.segment_valid, got.segment_valid,
                           want.search_done, got.search_done);
            end
         end
      end
      rsp_stall <= (hold_cnt != 0) || ($urandom_range(99) < rcv_idle_pct);
   end

   // Long hold-off counter for the backpressure test
   always @(posedge clock) begin
      if (hold_go) begin
         hold_cnt <= HOLD_CYCLES;
      end else if (hold_cnt != 0) begin
         hold_cnt <= hold_cnt - 1;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // Corner cases: idle input, search restart, each end-of-stream flavor,
   // DNL with zero and full height, and a second DNL after one was seen.
   task automatic test_directed_cases();
      write_dnl_scan(1'b1);
      send_byte(jrms_pkg::FILL_BYTE);   // byte while idle
      send_end();                       // end while idle
      arm_search();
      arm_search();                     // arm again mid-search
      send_byte(8'h00);                 // out of sync
      send_end();                       // end during resync
      arm_search();
      send_byte(jrms_pkg::FILL_BYTE);
      send_byte(jrms_pkg::DNL_CODE);
      send_end();                       // end during DNL length
      arm_search();
      send_byte(jrms_pkg::FILL_BYTE);
      send_byte(jrms_pkg::DNL_CODE);
      send_byte(jrms_pkg::DNL_LENGTH[15:8]);
      send_byte(jrms_pkg::DNL_LENGTH[7:0]);
      send_byte(8'h00);
      send_byte(8'h00);                 // zero height
      arm_search();
      send_byte(jrms_pkg::FILL_BYTE);
      send_byte(jrms_pkg::DNL_CODE);
      send_byte(jrms_pkg::DNL_LENGTH[15:8]);
      send_byte(jrms_pkg::DNL_LENGTH[7:0]);
      send_byte(8'hFF);
      send_byte(8'hFF);                 // largest height
      arm_search();
      send_byte(jrms_pkg::FILL_BYTE);
      send_byte(jrms_pkg::DNL_CODE);    // DNL already seen: marker left
      arm_search();
      send_end();                       // end during the marker search
   endtask

   task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct,
                                      input logic scan, input int unsigned n_items);
      int unsigned start;
      write_dnl_scan(scan);
      snd_idle_pct = snd_pct;
      rcv_idle_pct = rcv_pct;
      start = search_items;
      while (search_items - start < n_items)
         run_random_search();
   endtask

   // Receiver holds off while the sender keeps pushing: the unit must fill
   // its output and skid entries and then stall its input.
   task automatic test_receiver_holdoff();
      int unsigned start;
      write_dnl_scan(1'b1);
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      hold_go <= 1'b1;
      @(posedge clock);
      hold_go <= 1'b0;
      start = search_items;
      while (search_items - start < 40)
         run_random_search();
   endtask

   initial begin
      snd_idle_pct = 36;
      rcv_idle_pct = 64;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_traffic(36, 64, 1'b0, 620);
      test_random_traffic(64, 36, 1'b1, 620);
      test_random_traffic(0, 0, 1'b0, 560);
      test_receiver_holdoff();

      req_valid <= 1'b0;
      while (sync_results_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (bad_results == 0 && sync_results_due.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
